### hw/rtl/tspp_pkg.sv
// Types and constants for the trapezoid step-pulse profiler.
// No dependencies.
package tspp_pkg;

   typedef enum logic [2:0] {
      REQ_REL   = 3'd0,
      REQ_ABS   = 3'd1,
      REQ_TICK  = 3'd2,
      REQ_PULSE = 3'd3,
      REQ_CLEAR = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      PH_STOP   = 2'd0,
      PH_ACCEL  = 2'd1,
      PH_CRUISE = 2'd2,
      PH_DECEL  = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      CSR_MAX_FREQ   = 3'd0,
      CSR_START_FREQ = 3'd1,
      CSR_END_FREQ   = 3'd2,
      CSR_ACCEL_MS   = 3'd3,
      CSR_DECEL_MS   = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PLAN_AR_MUL,
      ST_PLAN_AR_DIV,
      ST_PLAN_DR_MUL,
      ST_PLAN_DR_DIV,
      ST_PLAN_AE_MUL,
      ST_PLAN_AE_DIV,
      ST_PLAN_DD_MUL,
      ST_PLAN_DD_DIV,
      ST_PLAN_FIN,
      ST_PULSE_MUL,
      ST_PULSE_DIV,
      ST_PULSE_FIN,
      ST_RELOAD_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [2:0]         req_type;
      logic signed [31:0] move_amount;
   } req_type_s_type;

   typedef struct packed {
      logic [15:0]        reload_value;
      logic [14:0]        compare_value;
      logic               direction;
      logic               running;
      logic signed [31:0] position;
      logic               status;
   } rsp_type_s_type;

   localparam int unsigned DIV_W = 48;

endpackage

### hw/rtl/tspp_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on tspp_pkg for the operand width.
module tspp_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [tspp_pkg::DIV_W-1:0] dividend,
   input  logic [tspp_pkg::DIV_W-1:0] divisor,
   output logic                      done,
   output logic [tspp_pkg::DIV_W-1:0] quotient
);
   import tspp_pkg::*;

   localparam int unsigned CW = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W:0]   rem_ff, rem_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DIV_W:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[DIV_W-1:0], quo_ff[DIV_W-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
   end

   assign done     = busy_ff && (cnt_ff == CW'(1));
   assign quotient = quo_in;

endmodule

### hw/rtl/trapezoid_step_pulse_profiler.sv
// Top level of the trapezoid step-pulse profiler: control sequencer and state.
// Depends on tspp_pkg and tspp_divider.
//
//  channel | ports      | dir | beat
//  req     | req_*      | in  | one event (move, tick, pulse done, clear)
//  rsp     | rsp_*      | out | one timer update per event
//  csr     | csr_*      | in  | register write, no handshake
//
// One beat at a time. A move costs four plan divisions plus the reload
// division, a pulse in accel or decel one ramp division plus the reload division;
// every division runs in the shared bit-serial divider.
// Tick and clear beats run only the reload division.
// Reset is synchronous; rsp holds its beat until taken, req waits meanwhile.
module trapezoid_step_pulse_profiler #(
   parameter int unsigned TIMER_CLOCK_HZ = 1000000,
   parameter int unsigned MIN_FREQ_HZ    = 20
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  tspp_pkg::req_type_s_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output tspp_pkg::rsp_type_s_type rsp_data,
   input  logic                    csr_write,
   input  logic [2:0]              csr_index,
   input  logic [16:0]             csr_data
);
   import tspp_pkg::*;

   // configuration
   logic [16:0] max_ff, start_ff, end_ff;
   logic [15:0] ams_ff, dms_ff;

   // profile state
   logic [31:0] pos_ff, pos_in;
   phase_type   ph_ff, ph_in;
   logic [31:0] pd_ff, pd_in;
   logic [31:0] len_ff, len_in;
   logic [15:0] ms_ff, ms_in;
   logic [31:0] ar_ff, ar_in, dr_ff, dr_in;
   logic signed [33:0] aep_ff, aep_in, dsp_ff, dsp_in;
   logic        short_ff, short_in;
   logic [16:0] cf_ff, cf_in;
   logic        dir_ff, dir_in;

   state_type   st_ff, st_in;
   logic [DIV_W-1:0] prod_ff, prod_in;     // registered multiplier result
   logic        status_ff, status_in;
   rsp_type_s_type out_ff, out_in;
   logic        ov_ff, ov_in;
   logic [1:0]  pkind_ff, pkind_in;        // pulse path: 0 none,1 accel,2 decel

   // divider
   logic             div_start, div_done;
   logic [DIV_W-1:0] div_a, div_b, div_q;

   tspp_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_a), .divisor(div_b), .done(div_done), .quotient(div_q)
   );

   // clamped frequencies and times
   logic [16:0] fs, fm, fe, fe0;
   logic [15:0] ta, td;
   always_comb begin
      fs  = (start_ff < 17'(MIN_FREQ_HZ)) ? 17'(MIN_FREQ_HZ) : start_ff;
      fm  = (max_ff < fs) ? fs : max_ff;
      fe0 = (end_ff < 17'(MIN_FREQ_HZ)) ? 17'(MIN_FREQ_HZ) : end_ff;
      fe  = (fe0 > fm) ? fm : fe0;
      ta  = (ams_ff == '0) ? 16'd1 : ams_ff;
      td  = (dms_ff == '0) ? 16'd1 : dms_ff;
   end

   // move decode
   logic [31:0] amt, rel_len, abs_len;
   logic        rel_neg, abs_back;
   always_comb begin
      amt      = req_data.move_amount;
      rel_neg  = amt[31];
      rel_len  = rel_neg ? (32'd0 - amt) : amt;
      abs_back = $signed(pos_ff) > $signed(amt);
      abs_len  = abs_back ? (pos_ff - amt) : (amt - pos_ff);
   end

   logic req_fire;
   assign req_fire  = req_valid && req_ready;
   assign req_ready = (st_ff == ST_IDLE) && !ov_ff;

   logic [DIV_W-1:0] ramp_f;
   logic [16:0]      base_f;

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (req_fire) begin
            if (req_data.req_type == REQ_REL && amt != '0)        st_in = ST_PLAN_AR_MUL;
            else if (req_data.req_type == REQ_ABS && pos_ff != amt) st_in = ST_PLAN_AR_MUL;
            else if (req_data.req_type == REQ_PULSE && ph_ff != PH_STOP) st_in = ST_PULSE_MUL;
            else st_in = ST_RELOAD_DIV;
         end
         ST_PLAN_AR_MUL: st_in = ST_PLAN_AR_DIV;
         ST_PLAN_AR_DIV: if (div_done) st_in = ST_PLAN_DR_MUL;
         ST_PLAN_DR_MUL: st_in = ST_PLAN_DR_DIV;
         ST_PLAN_DR_DIV: if (div_done) st_in = ST_PLAN_AE_MUL;
         ST_PLAN_AE_MUL: st_in = ST_PLAN_AE_DIV;
         ST_PLAN_AE_DIV: if (div_done) st_in = ST_PLAN_DD_MUL;
         ST_PLAN_DD_MUL: st_in = ST_PLAN_DD_DIV;
         ST_PLAN_DD_DIV: if (div_done) st_in = ST_PLAN_FIN;
         ST_PLAN_FIN:    st_in = ST_RELOAD_DIV;
         ST_PULSE_MUL:   st_in = (pkind_ff == 2'd0) ? ST_PULSE_FIN : ST_PULSE_DIV;
         ST_PULSE_DIV:   if (div_done) st_in = ST_PULSE_FIN;
         ST_PULSE_FIN:   st_in = ST_RELOAD_DIV;
         ST_RELOAD_DIV:  if (div_done) st_in = ST_OUT;
         ST_OUT:         st_in = ST_IDLE;
         default:        st_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      pos_in = pos_ff; ph_in = ph_ff; pd_in = pd_ff; len_in = len_ff; ms_in = ms_ff;
      ar_in = ar_ff; dr_in = dr_ff; aep_in = aep_ff; dsp_in = dsp_ff;
      short_in = short_ff; cf_in = cf_ff; dir_in = dir_ff;
      prod_in = prod_ff; status_in = status_ff; out_in = out_ff; pkind_in = pkind_ff;
      ov_in = ov_ff;
      div_start = 1'b0; div_a = prod_ff; div_b = '0;
      ramp_f = '0; base_f = (pkind_ff == 2'd1) ? fs : fe;
      if (ov_ff && rsp_ready) ov_in = 1'b0;
      unique case (st_ff)
         ST_IDLE: if (req_fire) begin
            status_in = 1'b0;
            case (req_data.req_type)
               REQ_REL: if (amt == '0) status_in = 1'b1;
                  else begin
                     pos_in = pos_ff + amt; dir_in = !rel_neg; len_in = rel_len;
                  end
               REQ_ABS: if (pos_ff == amt) status_in = 1'b1;
                  else begin
                     pos_in = amt; dir_in = !abs_back; len_in = abs_len;
                  end
               REQ_TICK:
                  if (ph_ff == PH_ACCEL) begin
                     if (ms_ff != 16'hFFFF) ms_in = ms_ff + 1'b1;
                  end else if (ph_ff == PH_DECEL && ms_ff != '0) ms_in = ms_ff - 1'b1;
               REQ_PULSE: if (ph_ff != PH_STOP) begin
                  pd_in = pd_ff + 1'b1;
                  pkind_in = (ph_ff == PH_ACCEL) ? 2'd1 : (ph_ff == PH_DECEL) ? 2'd2 : 2'd0;
               end
               REQ_CLEAR: pos_in = '0;
               default: ;
            endcase
         end
         ST_PLAN_AR_MUL: prod_in = DIV_W'(fm - fs) * DIV_W'(1000);
         ST_PLAN_DR_MUL: prod_in = DIV_W'(fm - fe) * DIV_W'(1000);
         ST_PLAN_AE_MUL: prod_in = DIV_W'(18'(fm) + 18'(fs)) * DIV_W'(ta);
         ST_PLAN_DD_MUL: prod_in = DIV_W'(18'(fm) + 18'(fe)) * DIV_W'(td);
         ST_PULSE_MUL: begin
            prod_in = DIV_W'((pkind_ff == 2'd1) ? ar_ff : dr_ff) * DIV_W'(ms_ff);
            div_start = (pkind_ff != 2'd0);
            div_a = DIV_W'((pkind_ff == 2'd1) ? ar_ff : dr_ff) * DIV_W'(ms_ff);
            div_b = DIV_W'(1000);
         end
         default: ;
      endcase
      // start each plan division in the same cycle that its product is latched
      if (st_ff == ST_PLAN_AR_MUL || st_ff == ST_PLAN_DR_MUL ||
          st_ff == ST_PLAN_AE_MUL || st_ff == ST_PLAN_DD_MUL) begin
         div_start = 1'b1;
         div_a = prod_in;
         div_b = (st_ff == ST_PLAN_AR_MUL) ? DIV_W'(ta) :
                 (st_ff == ST_PLAN_DR_MUL) ? DIV_W'(td) : DIV_W'(2000);
      end
      if (div_done) begin
         unique case (st_ff)
            ST_PLAN_AR_DIV: ar_in  = div_q[31:0];
            ST_PLAN_DR_DIV: dr_in  = div_q[31:0];
            ST_PLAN_AE_DIV: aep_in = 34'(div_q[31:0]);
            ST_PLAN_DD_DIV: dsp_in = $signed({2'b00, len_ff}) - $signed({2'b00, div_q[31:0]});
            ST_PULSE_DIV: begin
               ramp_f = DIV_W'(base_f) + div_q;
               cf_in  = (ramp_f > DIV_W'(fm)) ? fm : ramp_f[16:0];
            end
            default: ;
         endcase
      end
      if (st_ff == ST_PLAN_FIN) begin
         if (aep_ff > dsp_ff) begin short_in = 1'b1; aep_in = dsp_ff; end
         else short_in = 1'b0;
         cf_in = fs; ph_in = PH_ACCEL; pd_in = '0; ms_in = '0;
      end
      if (st_ff == ST_PULSE_FIN) begin
         if (ph_ff == PH_ACCEL) begin
            if ($signed({2'b00, pd_ff}) >= aep_ff) ph_in = PH_CRUISE;
         end else if (ph_ff == PH_CRUISE) begin
            if ($signed({2'b00, pd_ff}) >= dsp_ff) begin
               ph_in = PH_DECEL;
               if (!short_ff) ms_in = td;
            end
         end
         if (pd_ff == len_ff) ph_in = PH_STOP;
      end
      // reload: start on entry
      if (st_in == ST_RELOAD_DIV && st_ff != ST_RELOAD_DIV) begin
         div_start = 1'b1;
         div_a = DIV_W'(TIMER_CLOCK_HZ);
         div_b = DIV_W'(cf_in);
      end
      if (st_ff == ST_RELOAD_DIV && div_done) begin
         // quotient of zero divisor is all ones -> saturates
         if (div_q == '0)                          out_in.reload_value = '0;
         else if (div_q - 1'b1 > DIV_W'(16'hFFFF)) out_in.reload_value = 16'hFFFF;
         else out_in.reload_value = 16'(div_q - 1'b1);
         out_in.compare_value = out_in.reload_value[15:1];
         out_in.direction = dir_ff;
         out_in.running   = (ph_ff != PH_STOP);
         out_in.position  = pos_ff;
         out_in.status    = status_ff;
      end
      if (st_ff == ST_OUT) ov_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in; out_ff <= out_in; status_ff <= status_in; pkind_ff <= pkind_in;
      if (reset) begin
         st_ff <= ST_IDLE; ov_ff <= 1'b0;
         max_ff <= 17'd1000; start_ff <= 17'd20; end_ff <= 17'd20;
         ams_ff <= 16'd100; dms_ff <= 16'd100;
         pos_ff <= '0; ph_ff <= PH_STOP; pd_ff <= '0; len_ff <= '0; ms_ff <= '0;
         ar_ff <= '0; dr_ff <= '0; aep_ff <= '0; dsp_ff <= '0; short_ff <= 1'b0;
         cf_ff <= 17'(MIN_FREQ_HZ); dir_ff <= 1'b0;
      end else begin
         st_ff <= st_in; ov_ff <= ov_in;
         pos_ff <= pos_in; ph_ff <= ph_in; pd_ff <= pd_in; len_ff <= len_in;
         ms_ff <= ms_in; ar_ff <= ar_in; dr_ff <= dr_in; aep_ff <= aep_in;
         dsp_ff <= dsp_in; short_ff <= short_in; cf_ff <= cf_in; dir_ff <= dir_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_MAX_FREQ:   max_ff   <= csr_data;
               CSR_START_FREQ: start_ff <= csr_data;
               CSR_END_FREQ:   end_ff   <= csr_data;
               CSR_ACCEL_MS:   ams_ff   <= csr_data[15:0];
               CSR_DECEL_MS:   dms_ff   <= csr_data[15:0];
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;

endmodule

### hw/rtl/tspp_checker.sv
// Port-level checks for the trapezoid step-pulse profiler, with its bind.
// Depends on tspp_pkg.
module tspp_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input tspp_pkg::rsp_type_s_type rsp_data
);
   import tspp_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat dropped or changed");
   a_cmp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.compare_value == rsp_data.reload_value[15:1])
      else $error("compare not half reload");
   a_one: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second beat taken while busy");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("req taken while rsp beat waits");
endmodule

bind trapezoid_step_pulse_profiler tspp_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);
